// ===== rtl/gdc_pkg.sv =====
// Shared types, constants and calendar helpers for the Gregorian date counter.
package gdc_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int CNT_W   = 16;
    localparam int DIFF_W  = 23;
    localparam int NUM_W   = 23;   // day number from 1.1.0
    localparam int YY_W    = 15;   // working year, holds one past the top year
    localparam int REM_W   = 9;    // day within a year
    localparam int ACC_W   = 25;   // signed accumulator
    localparam int OPA_W   = 23;
    localparam int OPB_W   = 16;
    localparam int PROD_W  = OPA_W + OPB_W;

    localparam int MONTHS = 12;
    localparam logic [MONTH_W-1:0] MONTH_LAST = MONTH_W'(MONTHS);
    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [DAY_W-1:0]   LEAP_FEB_DAYS = 5'd29;

    localparam logic [DAY_W-1:0] MONTH_LEN [MONTHS] =
        '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};
    // days before the first of each month, common year
    localparam logic [REM_W-1:0] CUM_DAYS [MONTHS] =
        '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243, 9'd273,
          9'd304, 9'd334};

    // y divisible by 25 iff y * inv(25) mod 2^16 <= (2^16 - 1) / 25
    localparam logic [15:0] INV25       = 16'd23593;
    localparam logic [15:0] DIV25_LIMIT = 16'd2621;

    // x / 100 == (x * 5243) >> 19 for x below 43699
    localparam logic [OPB_W-1:0] RECIP100  = 16'd5243;
    localparam int               DIV100_SH = 19;
    // year estimate: n * 400 / 146097 ~ (n * 45934) >> 24
    localparam logic [OPB_W-1:0] EST_K  = 16'd45934;
    localparam int               EST_SH = 24;
    localparam logic [OPB_W-1:0] DAYS_PER_YEAR = 16'd365;
    localparam logic [OPB_W-1:0] UNIT          = 16'd1;

    localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd1;
    localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd1;
    localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd2000;
    localparam logic [NUM_W-1:0]   RESET_DAYNUM = 23'd730485;

    localparam logic signed [ACC_W-1:0] DIFF_MAX = 25'sd4194303;
    localparam logic signed [ACC_W-1:0] DIFF_MIN = -25'sd4194304;

    typedef enum logic [1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_ADD  = 2'd1,
        FUNC_SUB  = 2'd2,
        FUNC_CMP  = 2'd3
    } func_t;

    localparam logic [1:0] ORDER_EQ      = 2'd0;
    localparam logic [1:0] ORDER_EARLIER = 2'd1;
    localparam logic [1:0] ORDER_LATER   = 2'd2;

    typedef enum logic [1:0] {
        SH_NONE   = 2'd0,
        SH_DIV100 = 2'd1,
        SH_EST    = 2'd2
    } shift_t;

    typedef struct packed {
        logic              en;
        logic              clr;
        logic              sub;
        logic [OPA_W-1:0]  a;
        logic [OPB_W-1:0]  b;
        shift_t            sh;
    } alu_ctrl_t;

    function automatic logic is_leap(input logic [YY_W-1:0] y);
        logic [31:0] p;
        logic        div25;
        p     = 32'(y) * 32'(INV25);
        div25 = (p[15:0] <= DIV25_LIMIT);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m, input logic lp);
        logic [DAY_W-1:0] r;
        r = '0;
        if (m >= MONTH_JAN && m <= MONTH_LAST)
        begin
            r = MONTH_LEN[m - MONTH_JAN];
        end
        if (m == MONTH_FEB && lp)
        begin
            r = LEAP_FEB_DAYS;
        end
        return r;
    endfunction

    function automatic logic [REM_W-1:0] cum_days(input logic [MONTH_W-1:0] m, input logic lp);
        logic [REM_W-1:0] r;
        r = '0;
        if (m >= MONTH_JAN && m <= MONTH_LAST)
        begin
            r = CUM_DAYS[m - MONTH_JAN];
        end
        if (lp && m > MONTH_FEB)
        begin
            r = r + 9'd1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/gdc_if.sv =====
// Request and response channel interfaces of the date counter.
interface gdc_req_if;
    import gdc_pkg::*;
    logic                valid;
    logic                ready;
    func_t               func;
    logic [DAY_W-1:0]    in_day;
    logic [MONTH_W-1:0]  in_month;
    logic [YEAR_W-1:0]   in_year;
    logic [CNT_W-1:0]    day_count;

    modport source (output valid, func, in_day, in_month, in_year, day_count, input ready);
    modport sink   (input valid, func, in_day, in_month, in_year, day_count, output ready);
endinterface

interface gdc_rsp_if;
    import gdc_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [DAY_W-1:0]          cur_day;
    logic [MONTH_W-1:0]        cur_month;
    logic [YEAR_W-1:0]         cur_year;
    logic [1:0]                order;
    logic signed [DIFF_W-1:0]  day_diff;
    logic                      range_error;

    modport source (output valid, cur_day, cur_month, cur_year, order, day_diff, range_error,
                    input ready);
    modport sink   (input valid, cur_day, cur_month, cur_year, order, day_diff, range_error,
                    output ready);
endinterface

// ===== rtl/gdc_alu.sv =====
// Shared multiply-accumulate unit: acc <= (clr ? 0 : acc) +/- ((a * b) >> sh).
module gdc_alu (
    input  logic                          clk,
    input  gdc_pkg::alu_ctrl_t            ctrl,
    output logic signed [gdc_pkg::ACC_W-1:0] acc
);
    import gdc_pkg::*;

    logic [PROD_W-1:0]       prod;
    logic [PROD_W-1:0]       shifted;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] base;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] acc_reg;

    always_comb
    begin
        prod = PROD_W'(ctrl.a) * PROD_W'(ctrl.b);
        unique case (ctrl.sh)
            SH_NONE:   shifted = prod;
            SH_DIV100: shifted = prod >> DIV100_SH;
            SH_EST:    shifted = prod >> EST_SH;
            default:   shifted = prod;
        endcase
        term     = $signed({1'b0, shifted[ACC_W-2:0]});
        base     = ctrl.clr ? '0 : acc_reg;
        acc_next = ctrl.sub ? (base - term) : (base + term);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== rtl/gregorian_date_counter_core.sv =====
// Top level of the Gregorian date counter: sequencer, stored date and result register.
//
// Usage
//   req channel: one request carries func (load, add days, subtract days, compare),
//   a date (in_day, in_month, in_year) and day_count. rsp channel: one response per
//   request with the stored date after the operation, order and day_diff for compare,
//   and range_error for an invalid date or a move out of 1.1.0 .. 31.12.MAX_YEAR.
//   A request is taken only while the sequencer is idle; req.ready is low meanwhile.
// Sequence
//   Add and subtract run a year search that evaluates the start-of-year day number
//   in 5 passes through the shared multiply-accumulate unit plus a check step, two
//   or three times; the month walk then steps through the months one at a time.
//   Range errors finish early.
// Reset
//   rst_n clears the sequencer and the response valid, and sets the date to 1.1.2000.
// Stall
//   A finished response waits in the output register. The next request may be taken
//   and worked on; its response waits in the last step until rsp.ready frees the slot.
module gregorian_date_counter_core #(
    parameter int MAX_YEAR = 9999
) (
    input  logic       clk,
    input  logic       rst_n,
    gdc_req_if.sink    req,
    gdc_rsp_if.source  rsp
);
    import gdc_pkg::*;

    localparam logic [YEAR_W-1:0] MAX_YEAR_W = YEAR_W'(MAX_YEAR);
    // day number of 1.1.(MAX_YEAR + 1)
    localparam int YEAR_END_INT = 365 * (MAX_YEAR + 1) + (MAX_YEAR + 4) / 4
                                  - (MAX_YEAR + 100) / 100 + (MAX_YEAR + 400) / 400;
    localparam logic signed [ACC_W-1:0] YEAR_END = ACC_W'(YEAR_END_INT);

    typedef enum logic [19:0] {
        S_IDLE  = 20'h00001,
        S_LEAP  = 20'h00002,
        S_DISP  = 20'h00004,
        S_BASE  = 20'h00008,
        S_Y365  = 20'h00010,
        S_Q4    = 20'h00020,
        S_Q100  = 20'h00040,
        S_Q400  = 20'h00080,
        S_MD    = 20'h00100,
        S_LOAD  = 20'h00200,
        S_CMP   = 20'h00400,
        S_MOVE  = 20'h00800,
        S_RANGE = 20'h01000,
        S_EST   = 20'h02000,
        S_ESTLD = 20'h04000,
        S_YCHK  = 20'h08000,
        S_NCHK  = 20'h10000,
        S_WLEAP = 20'h20000,
        S_WALK  = 20'h40000,
        S_FIN   = 20'h80000
    } state_t;

    // what the current accumulate pass computes
    typedef enum logic [2:0] {
        M_LOAD = 3'd0,   // day number of the given date
        M_CMP  = 3'd1,   // given minus stored day number
        M_MOVE = 3'd2,   // stored day number +/- count
        M_YCUR = 3'd3,   // n - start of year yy
        M_YNXT = 3'd4    // n - start of year yy + 1
    } mode_t;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;

    func_t               func_reg;
    logic [DAY_W-1:0]    d_reg;
    logic [MONTH_W-1:0]  m_reg;
    logic [YEAR_W-1:0]   y_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                leap_reg;
    logic [NUM_W-1:0]    n_reg;
    logic [YY_W-1:0]     yy_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [MONTH_W-1:0]  mm_reg;

    logic [DAY_W-1:0]    cur_day_reg;
    logic [MONTH_W-1:0]  cur_month_reg;
    logic [YEAR_W-1:0]   cur_year_reg;
    logic [NUM_W-1:0]    cur_num_reg;

    logic                     err_reg;
    logic [1:0]               order_reg;
    logic [DIFF_W-1:0]        diff_reg;

    logic                     out_valid_reg;
    logic [DAY_W-1:0]         out_day_reg;
    logic [MONTH_W-1:0]       out_month_reg;
    logic [YEAR_W-1:0]        out_year_reg;
    logic [1:0]               out_order_reg;
    logic [DIFF_W-1:0]        out_diff_reg;
    logic                     out_err_reg;

    alu_ctrl_t               alu_ctrl;
    logic signed [ACC_W-1:0] acc;

    logic [YY_W-1:0]   year_op;
    logic              neg;
    logic [YY_W-1:0]   leap_src;
    logic              leap_now;
    logic              date_ok;
    logic [DAY_W-1:0]  dim_walk;
    logic              walk_step;
    logic              acc_neg;
    logic              out_free;
    logic              req_fire;

    gdc_alu u_alu (
        .clk  (clk),
        .ctrl (alu_ctrl),
        .acc  (acc)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign acc_neg   = acc[ACC_W-1];

    always_comb
    begin
        unique case (mode_reg)
            M_YCUR:  year_op = yy_reg;
            M_YNXT:  year_op = yy_reg + 15'd1;
            default: year_op = {1'b0, y_reg};
        endcase
        neg       = (mode_reg == M_YCUR) || (mode_reg == M_YNXT);
        leap_src  = (state_reg == S_WLEAP) ? yy_reg : {1'b0, y_reg};
        leap_now  = is_leap(leap_src);
        date_ok   = (y_reg <= MAX_YEAR_W) && (m_reg >= MONTH_JAN) && (m_reg <= MONTH_LAST)
                    && (d_reg != '0) && (d_reg <= days_in(m_reg, leap_reg));
        dim_walk  = days_in(mm_reg, leap_reg);
        walk_step = (mm_reg < MONTH_LAST) && (acc[REM_W-1:0] >= {4'b0, dim_walk});
    end

    // sequencer and shared unit control
    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        alu_ctrl.en  = 1'b0;
        alu_ctrl.clr = 1'b0;
        alu_ctrl.sub = 1'b0;
        alu_ctrl.a   = '0;
        alu_ctrl.b   = UNIT;
        alu_ctrl.sh  = SH_NONE;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_LEAP;
                end
            end
            S_LEAP:
            begin
                state_next = S_DISP;
            end
            S_DISP:
            begin
                unique case (func_reg)
                    FUNC_LOAD:
                    begin
                        mode_next  = M_LOAD;
                        state_next = date_ok ? S_BASE : S_FIN;
                    end
                    FUNC_CMP:
                    begin
                        mode_next  = M_CMP;
                        state_next = date_ok ? S_BASE : S_FIN;
                    end
                    default:
                    begin
                        mode_next  = M_MOVE;
                        state_next = S_BASE;
                    end
                endcase
            end
            S_BASE:
            begin
                alu_ctrl.en  = 1'b1;
                alu_ctrl.clr = 1'b1;
                unique case (mode_reg)
                    M_LOAD:  alu_ctrl.a = '0;
                    M_CMP:
                    begin
                        alu_ctrl.a   = cur_num_reg;
                        alu_ctrl.sub = 1'b1;
                    end
                    M_MOVE:  alu_ctrl.a = cur_num_reg;
                    default: alu_ctrl.a = n_reg;
                endcase
                state_next = (mode_reg == M_MOVE) ? S_MOVE : S_Y365;
            end
            S_Y365:
            begin
                alu_ctrl.en  = 1'b1;
                alu_ctrl.sub = neg;
                alu_ctrl.a   = OPA_W'(year_op);
                alu_ctrl.b   = DAYS_PER_YEAR;
                state_next   = S_Q4;
            end
            S_Q4:
            begin
                alu_ctrl.en  = 1'b1;
                alu_ctrl.sub = neg;
                alu_ctrl.a   = OPA_W'((year_op + 15'd3) >> 2);
                state_next   = S_Q100;
            end
            S_Q100:
            begin
                alu_ctrl.en  = 1'b1;
                alu_ctrl.sub = !neg;
                alu_ctrl.a   = OPA_W'(year_op + 15'd99);
                alu_ctrl.b   = RECIP100;
                alu_ctrl.sh  = SH_DIV100;
                state_next   = S_Q400;
            end
            S_Q400:
            begin
                alu_ctrl.en  = 1'b1;
                alu_ctrl.sub = neg;
                alu_ctrl.a   = OPA_W'((year_op + 15'd399) >> 2);
                alu_ctrl.b   = RECIP100;
                alu_ctrl.sh  = SH_DIV100;
                unique case (mode_reg)
                    M_YCUR:  state_next = S_YCHK;
                    M_YNXT:  state_next = S_NCHK;
                    default: state_next = S_MD;
                endcase
            end
            S_MD:
            begin
                alu_ctrl.en = 1'b1;
                alu_ctrl.a  = OPA_W'(cum_days(m_reg, leap_reg) + REM_W'(d_reg) - 9'd1);
                state_next  = (mode_reg == M_LOAD) ? S_LOAD : S_CMP;
            end
            S_LOAD:
            begin
                state_next = S_FIN;
            end
            S_CMP:
            begin
                state_next = S_FIN;
            end
            S_MOVE:
            begin
                alu_ctrl.en  = 1'b1;
                alu_ctrl.sub = (func_reg == FUNC_SUB);
                alu_ctrl.a   = OPA_W'(cnt_reg);
                state_next   = S_RANGE;
            end
            S_RANGE:
            begin
                state_next = (acc_neg || acc >= YEAR_END) ? S_FIN : S_EST;
            end
            S_EST:
            begin
                alu_ctrl.en  = 1'b1;
                alu_ctrl.clr = 1'b1;
                alu_ctrl.a   = n_reg;
                alu_ctrl.b   = EST_K;
                alu_ctrl.sh  = SH_EST;
                state_next   = S_ESTLD;
            end
            S_ESTLD:
            begin
                mode_next  = M_YCUR;
                state_next = S_BASE;
            end
            S_YCHK:
            begin
                // estimate too high: step down, else try the following year
                if (!acc_neg)
                begin
                    mode_next = M_YNXT;
                end
                state_next = S_BASE;
            end
            S_NCHK:
            begin
                state_next = acc_neg ? S_WLEAP : S_BASE;
            end
            S_WLEAP:
            begin
                alu_ctrl.en  = 1'b1;
                alu_ctrl.clr = 1'b1;
                alu_ctrl.a   = OPA_W'(rem_reg);
                state_next   = S_WALK;
            end
            S_WALK:
            begin
                if (walk_step)
                begin
                    alu_ctrl.en  = 1'b1;
                    alu_ctrl.sub = 1'b1;
                    alu_ctrl.a   = OPA_W'(dim_walk);
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state and the stored date
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= M_LOAD;
            out_valid_reg <= 1'b0;
            cur_day_reg   <= RESET_DAY;
            cur_month_reg <= RESET_MONTH;
            cur_year_reg  <= RESET_YEAR;
            cur_num_reg   <= RESET_DAYNUM;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            if (state_reg == S_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_LOAD)
            begin
                cur_day_reg   <= d_reg;
                cur_month_reg <= m_reg;
                cur_year_reg  <= y_reg;
                cur_num_reg   <= acc[NUM_W-1:0];
            end
            else if (state_reg == S_WALK && !walk_step)
            begin
                cur_day_reg   <= acc[DAY_W-1:0] + 5'd1;
                cur_month_reg <= mm_reg;
                cur_year_reg  <= yy_reg[YEAR_W-1:0];
                cur_num_reg   <= n_reg;
            end
        end
    end

    // working registers and response payload
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            func_reg  <= req.func;
            d_reg     <= req.in_day;
            m_reg     <= req.in_month;
            y_reg     <= req.in_year;
            cnt_reg   <= req.day_count;
            err_reg   <= 1'b0;
            order_reg <= ORDER_EQ;
            diff_reg  <= '0;
        end
        if (state_reg == S_LEAP || state_reg == S_WLEAP)
        begin
            leap_reg <= leap_now;
        end
        if (state_reg == S_WLEAP)
        begin
            mm_reg <= MONTH_JAN;
        end
        if (state_reg == S_WALK && walk_step)
        begin
            mm_reg <= mm_reg + 4'd1;
        end
        if (state_reg == S_DISP && (func_reg == FUNC_LOAD || func_reg == FUNC_CMP) && !date_ok)
        begin
            err_reg <= 1'b1;
        end
        if (state_reg == S_RANGE)
        begin
            if (acc_neg || acc >= YEAR_END)
            begin
                err_reg <= 1'b1;
            end
            n_reg <= acc[NUM_W-1:0];
        end
        if (state_reg == S_ESTLD)
        begin
            yy_reg <= acc[YY_W-1:0];
        end
        if (state_reg == S_YCHK)
        begin
            if (acc_neg)
            begin
                yy_reg <= yy_reg - 15'd1;
            end
            else
            begin
                rem_reg <= acc[REM_W-1:0];
            end
        end
        if (state_reg == S_NCHK && !acc_neg)
        begin
            yy_reg  <= yy_reg + 15'd1;
            rem_reg <= acc[REM_W-1:0];
        end
        if (state_reg == S_CMP)
        begin
            if (acc > DIFF_MAX)
            begin
                diff_reg <= DIFF_MAX[DIFF_W-1:0];
            end
            else if (acc < DIFF_MIN)
            begin
                diff_reg <= DIFF_MIN[DIFF_W-1:0];
            end
            else
            begin
                diff_reg <= acc[DIFF_W-1:0];
            end
            if (acc_neg)
            begin
                order_reg <= ORDER_LATER;
            end
            else if (acc != '0)
            begin
                order_reg <= ORDER_EARLIER;
            end
        end
        if (state_reg == S_FIN && out_free)
        begin
            out_day_reg   <= cur_day_reg;
            out_month_reg <= cur_month_reg;
            out_year_reg  <= cur_year_reg;
            out_order_reg <= order_reg;
            out_diff_reg  <= diff_reg;
            out_err_reg   <= err_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.cur_day     = out_day_reg;
    assign rsp.cur_month   = out_month_reg;
    assign rsp.cur_year    = out_year_reg;
    assign rsp.order       = out_order_reg;
    assign rsp.day_diff    = $signed(out_diff_reg);
    assign rsp.range_error = out_err_reg;

`ifndef SYNTHESIS
    // the stored month is always a real month
    a_month_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_month_reg >= MONTH_JAN) && (cur_month_reg <= MONTH_LAST))
        else $error("stored month out of range");

    // a response only appears out of the final step
    a_rsp_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("response raised outside the final step");

    // an error response never carries an ordering
    a_err_no_order: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.range_error && (rsp.order != ORDER_EQ)))
        else $error("error response with nonzero order");

    // the stored day number moves only on a load or at the end of a month walk
    a_date_update: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(cur_num_reg) |-> $past(state_reg == S_LOAD || state_reg == S_WALK))
        else $error("stored date changed outside an update step");
`endif

endmodule

// ===== verif/gregorian_date_counter_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the Gregorian date counter core: directed and random requests.
module gregorian_date_counter_core_tb;
    import gdc_pkg::*;

    localparam int TOP_YEAR     = 9999;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 1275;
    // Long response back-pressure; far above the slowest add/subtract.
    localparam int RSP_HOLD_CYCLES = 300;
    // Quiet time after the last response; covers the longest add/subtract latency.
    localparam int DRAIN_CYCLES = 100;
    // Watchdog limit, many times the slowest legal run.
    localparam int TIMEOUT_NS = 20_000_000;

    // One response as the block should present it.
    typedef struct {
        logic [DAY_W-1:0]         day;
        logic [MONTH_W-1:0]       month;
        logic [YEAR_W-1:0]        year;
        logic [1:0]               order;
        logic signed [DIFF_W-1:0] diff;
        logic                     range_error;
    } date_result_t;

    // Calendar predictor plus the queue of responses still owed by the block.
    class date_scoreboard;
        int                   max_year;
        logic [DAY_W-1:0]     day;
        logic [MONTH_W-1:0]   month;
        logic [YEAR_W-1:0]    year;
        date_result_t         expected_q[$];
        int                   error_count;

        function new(int top_year);
            max_year    = top_year;
            day         = RESET_DAY;
            month       = RESET_MONTH;
            year        = RESET_YEAR;
            error_count = 0;
        endfunction

        static function bit leap_year(longint y);
            return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        endfunction

        static function int month_days(longint m, longint y);
            if (m < 1 || m > 12)
            begin
                return 0;
            end
            case (m)
                2:          return leap_year(y) ? 29 : 28;
                4, 6, 9, 11: return 30;
                default:    return 31;
            endcase
        endfunction

        // Days from 1.1.0 up to 1.1.y.
        static function longint first_day_of_year(longint y);
            return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        endfunction

        static function longint date_to_daynum(longint d, longint m, longint y);
            longint n;
            n = first_day_of_year(y);
            for (longint k = 1; k < m; k++)
            begin
                n += month_days(k, y);
            end
            return n + d - 1;
        endfunction

        static function void daynum_to_date(longint n, output logic [DAY_W-1:0] d,
                                            output logic [MONTH_W-1:0] m,
                                            output logic [YEAR_W-1:0] y);
            longint yy;
            longint mm;
            yy = (n * 400) / 146097;
            while (yy > 0 && first_day_of_year(yy) > n)
            begin
                yy--;
            end
            while (first_day_of_year(yy + 1) <= n)
            begin
                yy++;
            end
            n -= first_day_of_year(yy);
            mm = 1;
            while (mm < 12 && n >= month_days(mm, yy))
            begin
                n -= month_days(mm, yy);
                mm++;
            end
            d = DAY_W'(n + 1);
            m = MONTH_W'(mm);
            y = YEAR_W'(yy);
        endfunction

        function bit valid_date(longint d, longint m, longint y);
            if (y > max_year || m < 1 || m > 12)
            begin
                return 1'b0;
            end
            return d >= 1 && d <= month_days(m, y);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Accepted request: advance the stored date and queue the response it owes.
        function void note_request(func_t f, logic [DAY_W-1:0] d, logic [MONTH_W-1:0] m,
                                   logic [YEAR_W-1:0] y, logic [CNT_W-1:0] cnt);
            date_result_t r;
            longint       cur;
            longint       steps;
            longint       moved;
            longint       gap;
            cur           = date_to_daynum(day, month, year);
            steps         = cnt;
            r.order       = ORDER_EQ;
            r.diff        = '0;
            r.range_error = 1'b0;
            case (f)
                FUNC_LOAD:
                begin
                    if (valid_date(d, m, y))
                    begin
                        day   = d;
                        month = m;
                        year  = y;
                    end
                    else
                    begin
                        r.range_error = 1'b1;
                    end
                end
                FUNC_ADD, FUNC_SUB:
                begin
                    moved = (f == FUNC_ADD) ? cur + steps : cur - steps;
                    // out of 1.1.0 .. 31.12.max_year: flag and keep the date
                    if (moved < 0 || moved >= first_day_of_year(max_year + 1))
                    begin
                        r.range_error = 1'b1;
                    end
                    else
                    begin
                        daynum_to_date(moved, day, month, year);
                    end
                end
                default:
                begin
                    if (valid_date(d, m, y))
                    begin
                        gap     = date_to_daynum(d, m, y) - cur;
                        r.order = (gap > 0) ? ORDER_EARLIER : (gap < 0) ? ORDER_LATER : ORDER_EQ;
                        if (gap > DIFF_MAX)
                        begin
                            gap = DIFF_MAX;
                        end
                        if (gap < DIFF_MIN)
                        begin
                            gap = DIFF_MIN;
                        end
                        r.diff = DIFF_W'(gap);
                    end
                    else
                    begin
                        r.range_error = 1'b1;
                    end
                end
            endcase
            r.day   = day;
            r.month = month;
            r.year  = year;
            expected_q.push_back(r);
        endfunction

        function void check_field(string name, logic signed [63:0] want,
                                  logic signed [63:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                error_count++;
            end
        endfunction

        function void check_response(logic [DAY_W-1:0] d, logic [MONTH_W-1:0] m,
                                     logic [YEAR_W-1:0] y, logic [1:0] ord,
                                     logic signed [DIFF_W-1:0] diff, logic err);
            date_result_t want;
            if (expected_q.size() == 0)
            begin
                $error("response with no request outstanding: %0d.%0d.%0d", d, m, y);
                error_count++;
                return;
            end
            want = expected_q.pop_front();
            check_field("cur_day", want.day, d);
            check_field("cur_month", want.month, m);
            check_field("cur_year", want.year, y);
            check_field("order", want.order, ord);
            check_field("day_diff", want.diff, diff);
            check_field("range_error", want.range_error, err);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    gdc_req_if req_ch ();
    gdc_rsp_if rsp_ch ();

    date_scoreboard board = new(TOP_YEAR);

    // Idle rates in percent, changed per phase by the stimulus.
    int send_idle_pct;
    int recv_idle_pct;
    // Set by the stimulus to request one long response stall.
    bit rsp_hold_request = 1'b0;

    gregorian_date_counter_core #(
        .MAX_YEAR (TOP_YEAR)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Present one request from a falling edge, with random idle cycles ahead of it,
    // and hold it until accepted. Returns just after the accepting rising edge with
    // valid still high; the next call or a pause settles valid at the next falling edge.
    task automatic send_request(func_t f, logic [DAY_W-1:0] d, logic [MONTH_W-1:0] m,
                                logic [YEAR_W-1:0] y, logic [CNT_W-1:0] cnt);
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.func      <= f;
        req_ch.in_day    <= d;
        req_ch.in_month  <= m;
        req_ch.in_year   <= y;
        req_ch.day_count <= cnt;
        do
        begin
            @(posedge clk);
        end
        while (req_ch.ready !== 1'b1);
        board.note_request(f, d, m, y, cnt);
    endtask

    // Sender pause: drop valid and wait until every owed response has come back.
    task automatic wait_until_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Response side: random ready, plus one long hold-off on request. The block
    // keeps its output register full and then stops taking requests.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rsp_hold_request)
            begin
                for (int n = 0; n < RSP_HOLD_CYCLES; n++)
                begin
                    rsp_ch.ready <= 1'b0;
                    @(negedge clk);
                end
                rsp_hold_request = 1'b0;
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Response monitor: every handshake is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            board.check_response(rsp_ch.cur_day, rsp_ch.cur_month, rsp_ch.cur_year,
                                 rsp_ch.order, rsp_ch.day_diff, rsp_ch.range_error);
        end
    end

    initial
    begin
        func_t               f;
        logic [DAY_W-1:0]    d;
        logic [MONTH_W-1:0]  m;
        logic [YEAR_W-1:0]   y;
        logic [CNT_W-1:0]    cnt;
        int                  pick;

        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.func      = FUNC_LOAD;
        req_ch.in_day    = '0;
        req_ch.in_month  = '0;
        req_ch.in_year   = '0;
        req_ch.day_count = '0;
        rsp_ch.ready     = 1'b0;
        send_idle_pct    = 20;
        recv_idle_pct    = 54;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset date, both ends of the calendar, leap rules, bad dates.
        send_request(FUNC_CMP,  1,  1, 2000, 0);       // equal to the reset date
        send_request(FUNC_CMP,  2,  1, 2000, 0);       // given one day later
        send_request(FUNC_LOAD, 1,  1, 0, 0);          // first day of the range
        send_request(FUNC_SUB,  31, 15, 16383, 1);     // underflow, date held
        send_request(FUNC_SUB,  0,  0, 0, 0);          // zero count
        send_request(FUNC_ADD,  0,  0, 0, 0);
        send_request(FUNC_CMP,  31, 12, YEAR_W'(TOP_YEAR), 0);  // widest positive difference
        send_request(FUNC_LOAD, 31, 12, YEAR_W'(TOP_YEAR), 0);  // last day of the range
        send_request(FUNC_ADD,  0,  0, 0, 1);          // overflow, date held
        send_request(FUNC_SUB,  0,  0, 0, 16'hFFFF);
        send_request(FUNC_ADD,  0,  0, 0, 16'hFFFF);
        send_request(FUNC_CMP,  1,  1, 0, 0);          // widest negative difference
        send_request(FUNC_LOAD, 29, 2, 2000, 0);       // leap by the 400 rule
        send_request(FUNC_LOAD, 29, 2, 1900, 0);       // century, not leap
        send_request(FUNC_LOAD, 29, 2, 2004, 0);
        send_request(FUNC_ADD,  31, 15, 16383, 16'hFFFF);
        send_request(FUNC_LOAD, 31, 4, 2004, 0);       // day past month end
        send_request(FUNC_LOAD, 0,  5, 2004, 0);       // day zero
        send_request(FUNC_LOAD, 1,  0, 2004, 0);       // month zero
        send_request(FUNC_LOAD, 1,  13, 2004, 0);
        send_request(FUNC_LOAD, 31, 15, 16383, 0);     // every date bit set
        send_request(FUNC_LOAD, 1,  1, YEAR_W'(TOP_YEAR + 1), 0);
        send_request(FUNC_CMP,  0,  0, 0, 0);          // bad compare date
        send_request(FUNC_CMP,  31, 12, 1999, 0);
        send_request(FUNC_SUB,  0,  0, 0, 16'hFFFF);

        // Random: mostly valid dates with mixed counts; some raw field noise.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 100)
            begin
                rsp_hold_request = 1'b1;
            end
            if (i == RANDOM_ITEMS / 3)
            begin
                wait_until_drained();
                send_idle_pct = 54;
                recv_idle_pct = 20;
            end
            if (i == 2 * RANDOM_ITEMS / 3)
            begin
                wait_until_drained();
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            pick = $urandom_range(99);
            f = (pick < 20) ? FUNC_LOAD : (pick < 55) ? FUNC_ADD :
                (pick < 80) ? FUNC_SUB : FUNC_CMP;

            // year: century edges and both ends of the range are favored
            case ($urandom_range(9))
                0:
                begin
                    case ($urandom_range(5))
                        0:       y = 0;
                        1:       y = 1600;
                        2:       y = 1900;
                        3:       y = 2000;
                        4:       y = 2100;
                        default: y = YEAR_W'(TOP_YEAR);
                    endcase
                end
                1:       y = YEAR_W'($urandom_range(TOP_YEAR - 99, TOP_YEAR));
                2:       y = YEAR_W'($urandom_range(0, 99));
                default: y = YEAR_W'($urandom_range(0, TOP_YEAR));
            endcase
            m = MONTH_W'($urandom_range(1, 12));
            d = DAY_W'($urandom_range(1, date_scoreboard::month_days(m, y)));

            pick = $urandom_range(99);
            if (pick < 15)
            begin
                d = DAY_W'($urandom);
                m = MONTH_W'($urandom);
                y = YEAR_W'($urandom);
            end
            else if (pick < 20)
            begin
                d = 29;
                m = 2;
            end
            else if (pick < 25)
            begin
                d = board.day;
                m = board.month;
                y = board.year;
            end
            else if (pick < 40)
            begin
                d = DAY_W'(date_scoreboard::month_days(m, y));
            end

            case ($urandom_range(9))
                0:       cnt = '0;
                1:       cnt = '1;
                2, 3, 4: cnt = CNT_W'($urandom_range(0, 400));
                5, 6, 7: cnt = CNT_W'($urandom);
                default: cnt = CNT_W'($urandom_range(1, 60));
            endcase

            send_request(f, d, m, y, cnt);
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.error_count == 0 && board.pending() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/gdc_pkg.sv
rtl/gdc_if.sv
rtl/gdc_alu.sv
rtl/gregorian_date_counter_core.sv
verif/gregorian_date_counter_core_tb.sv
